// ===== src/ise_pkg.sv =====
// ----------------------------------------------------------------------------
// ise_pkg
// Shared types and constants for the integer stack engine: stack sizing,
// instruction and status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package ise_pkg;

   // stack sizing
   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DATA_W      = 32;
   localparam int KIND_W      = 3;
   localparam int STATUS_W    = 2;

   // instruction codes
   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 3'd0,
      KIND_PRINT = 3'd1,
      KIND_PEEK  = 3'd2,
      KIND_POP   = 3'd3,
      KIND_SUB   = 3'd4
   } kind_type;

   // status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_SHORT = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP_WAIT,
      ST_SUB_WAIT,
      ST_PRINT_EMIT
   } state_type;

   // one result item
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     has_value;
      status_type               status;
      logic                     last;
   } rsp_type;

endpackage

// ===== src/ise_ram.sv =====
// ----------------------------------------------------------------------------
// ise_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds until the next read is issued.
// ----------------------------------------------------------------------------
module ise_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/ise_ctrl.sv =====
// ----------------------------------------------------------------------------
// ise_ctrl
// Instruction sequencer. Holds the top entry and entry count in registers,
// the entries below the top in the stack RAM. Pop and subtract fetch any new
// top from RAM; print all walks the RAM one entry per cycle unless stalled.
// ----------------------------------------------------------------------------
module ise_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   // request side
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ise_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [ise_pkg::DATA_W-1:0]     req_operand,
   // result register handshake
   input  logic                                  slot_free,
   output logic                                  rsp_load,
   output ise_pkg::rsp_type                      rsp_data,
   // stack RAM
   output logic                                  ram_we,
   output logic [ise_pkg::ADDR_W-1:0]            ram_waddr,
   output logic [ise_pkg::DATA_W-1:0]            ram_wdata,
   output logic                                  ram_re,
   output logic [ise_pkg::ADDR_W-1:0]            ram_raddr,
   input  logic [ise_pkg::DATA_W-1:0]            ram_rdata
);

   ise_pkg::state_type                   state_ff, state_in;
   logic [ise_pkg::CNT_W-1:0]            count_ff, count_in;
   logic signed [ise_pkg::DATA_W-1:0]    top_ff, top_in;
   logic [ise_pkg::ADDR_W-1:0]           idx_ff, idx_in;
   logic [ise_pkg::CNT_W-1:0]            n_m1;
   logic [ise_pkg::CNT_W-1:0]            n_m2;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ise_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // cached top and print index
   always_ff @(posedge clock) begin
      top_ff <= top_in;
      idx_ff <= idx_in;
   end

   assign n_m1 = count_ff - ise_pkg::CNT_W'(1);
   assign n_m2 = count_ff - ise_pkg::CNT_W'(2);

   // next state and outputs
   always_comb begin
      state_in           = state_ff;
      count_in           = count_ff;
      top_in             = top_ff;
      idx_in             = idx_ff;
      req_stall          = 1'b1;
      rsp_load           = 1'b0;
      rsp_data.value     = '0;
      rsp_data.has_value = 1'b0;
      rsp_data.status    = ise_pkg::STAT_OK;
      rsp_data.last      = 1'b1;
      ram_we             = 1'b0;
      ram_waddr          = n_m1[ise_pkg::ADDR_W-1:0];
      ram_wdata          = top_ff;
      ram_re             = 1'b0;
      ram_raddr          = n_m2[ise_pkg::ADDR_W-1:0];

      unique case (state_ff)
         ise_pkg::ST_IDLE: begin
            req_stall = !slot_free;
            if (req_valid && slot_free) begin
               unique case (req_kind)
                  ise_pkg::KIND_PUSH: begin
                     rsp_load = 1'b1;
                     if (count_ff == ise_pkg::CNT_W'(ise_pkg::STACK_DEPTH)) begin
                        rsp_data.status = ise_pkg::STAT_FULL;
                     end else begin
                        // old top spills into RAM
                        ram_we   = (count_ff != '0);
                        top_in   = req_operand;
                        count_in = count_ff + ise_pkg::CNT_W'(1);
                     end
                  end
                  ise_pkg::KIND_PRINT: begin
                     rsp_load = 1'b1;
                     if (count_ff != '0) begin
                        rsp_data.value     = top_ff;
                        rsp_data.has_value = 1'b1;
                        rsp_data.last      = (count_ff == ise_pkg::CNT_W'(1));
                        if (count_ff != ise_pkg::CNT_W'(1)) begin
                           // fetch the entry below the top
                           idx_in   = n_m2[ise_pkg::ADDR_W-1:0];
                           ram_re   = 1'b1;
                           state_in = ise_pkg::ST_PRINT_EMIT;
                        end
                     end
                  end
                  ise_pkg::KIND_PEEK: begin
                     rsp_load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_data.status = ise_pkg::STAT_EMPTY;
                     end else begin
                        rsp_data.value     = top_ff;
                        rsp_data.has_value = 1'b1;
                     end
                  end
                  ise_pkg::KIND_POP: begin
                     rsp_load = 1'b1;
                     if (count_ff == '0) begin
                        rsp_data.status = ise_pkg::STAT_EMPTY;
                     end else begin
                        count_in = n_m1;
                        if (count_ff != ise_pkg::CNT_W'(1)) begin
                           ram_re   = 1'b1;
                           state_in = ise_pkg::ST_POP_WAIT;
                        end
                     end
                  end
                  ise_pkg::KIND_SUB: begin
                     rsp_load = 1'b1;
                     if (count_ff < ise_pkg::CNT_W'(2)) begin
                        rsp_data.status = ise_pkg::STAT_SHORT;
                     end else begin
                        count_in = n_m1;
                        ram_re   = 1'b1;
                        state_in = ise_pkg::ST_SUB_WAIT;
                     end
                  end
                  default: begin
                     // unknown instruction: no item, no change
                  end
               endcase
            end
         end
         ise_pkg::ST_POP_WAIT: begin
            top_in   = ram_rdata;
            state_in = ise_pkg::ST_IDLE;
         end
         ise_pkg::ST_SUB_WAIT: begin
            // second minus top, wrapping
            top_in   = ram_rdata - top_ff;
            state_in = ise_pkg::ST_IDLE;
         end
         ise_pkg::ST_PRINT_EMIT: begin
            if (slot_free) begin
               rsp_load           = 1'b1;
               rsp_data.value     = ram_rdata;
               rsp_data.has_value = 1'b1;
               rsp_data.last      = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ise_pkg::ST_IDLE;
               end else begin
                  // prefetch the next entry down
                  idx_in    = idx_ff - ise_pkg::ADDR_W'(1);
                  ram_re    = 1'b1;
                  ram_raddr = idx_ff - ise_pkg::ADDR_W'(1);
               end
            end
         end
         default: begin
            state_in = ise_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== src/integer_stack_engine.sv =====
// ----------------------------------------------------------------------------
// integer_stack_engine
// Bounded LIFO stack machine on signed 32-bit integers.
// ----------------------------------------------------------------------------
// Executes one stack instruction per request item: push, print all, peek,
// pop and subtract. The top entry is held in a register and the rest of the
// stack in a 64-entry RAM with a registered read. Push, peek, pop of
// the last entry, print all on an empty or one-entry stack, every error and
// unknown codes finish in the idle state; pop with two or more entries and
// subtract pass through a wait state, since the new top comes back through
// the RAM read. Print all emits one item per cycle while the result side
// does not stall. Results are held in an output register, so a request is
// taken while the previous result still waits, as long as that register is
// free at the end of the cycle. Errors (empty, too short, full) are reported
// in status and leave the stack unchanged.
// ----------------------------------------------------------------------------
module integer_stack_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ise_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [ise_pkg::DATA_W-1:0]     req_operand,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [ise_pkg::DATA_W-1:0]     rsp_result_value,
   output logic                                  rsp_has_value,
   output logic [ise_pkg::STATUS_W-1:0]          rsp_status,
   output logic                                  rsp_last
);

   logic                          slot_free;
   logic                          rsp_load;
   ise_pkg::rsp_type              rsp_data;
   ise_pkg::rsp_type              rsp_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          ram_we;
   logic [ise_pkg::ADDR_W-1:0]    ram_waddr;
   logic [ise_pkg::DATA_W-1:0]    ram_wdata;
   logic                          ram_re;
   logic [ise_pkg::ADDR_W-1:0]    ram_raddr;
   logic [ise_pkg::DATA_W-1:0]    ram_rdata;

   // sequencer
   ise_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_kind    (req_kind),
      .req_operand (req_operand),
      .slot_free   (slot_free),
      .rsp_load    (rsp_load),
      .rsp_data    (rsp_data),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .ram_rdata   (ram_rdata)
   );

   // entries below the top
   ise_ram #(
      .WIDTH (ise_pkg::DATA_W),
      .DEPTH (ise_pkg::STACK_DEPTH)
   ) u_stack_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // output register: free when empty or being taken this cycle
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_data;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_ff.value;
   assign rsp_has_value    = rsp_ff.has_value;
   assign rsp_status       = rsp_ff.status;
   assign rsp_last         = rsp_ff.last;

endmodule

// ===== src/ise_chk.sv =====
// ----------------------------------------------------------------------------
// ise_chk
// Port-level checks for the integer stack engine, bound to the top level.
// ----------------------------------------------------------------------------
module ise_chk (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic [ise_pkg::KIND_W-1:0]            req_kind,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [ise_pkg::DATA_W-1:0]     rsp_result_value,
   input logic                                  rsp_has_value,
   input logic [ise_pkg::STATUS_W-1:0]          rsp_status,
   input logic                                  rsp_last
);

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_has_value) && $stable(rsp_status) && $stable(rsp_last))
      else $error("result item changed while stalled");

   // an item without a value carries zero
   a_no_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_value |-> rsp_result_value == '0)
      else $error("result value not zero without has_value");

   // an error status is always the only item of its instruction
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ise_pkg::STAT_OK |-> rsp_last && !rsp_has_value)
      else $error("error item not final or carries a value");

   // push answers in the next cycle with a single final item
   a_push_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == ise_pkg::KIND_PUSH
         |=> rsp_valid && rsp_last && !rsp_has_value)
      else $error("push did not answer with one final item");

endmodule

bind integer_stack_engine ise_chk u_ise_chk (.*);
